[rtl/core/c2d_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the 2-D convolution core.
`timescale 1ns / 1ps
package c2d_pkg;

	// Default sizing of the core.
	localparam int MAX_KERNEL_DEF = 18;
	localparam int MAX_COLS_DEF   = 1024;
	localparam int MAX_ROWS_DEF   = 1024;

	// Configuration register widths and reset values.
	localparam int DIM_REG_W = 11;
	localparam int KER_REG_W = 5;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 3;

	localparam logic [DIM_REG_W-1:0] RST_IMAGE_ROWS = DIM_REG_W'(1024);
	localparam logic [DIM_REG_W-1:0] RST_IMAGE_COLS = DIM_REG_W'(1024);
	localparam logic [KER_REG_W-1:0] RST_KERNEL_ROWS = KER_REG_W'(6);
	localparam logic [KER_REG_W-1:0] RST_KERNEL_COLS = KER_REG_W'(6);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_ROWS  = 3'd0,
		REG_IMAGE_COLS  = 3'd1,
		REG_KERNEL_ROWS = 3'd2,
		REG_KERNEL_COLS = 3'd3,
		REG_SYM_FOLD    = 3'd4
	} c2d_reg_t;

	// Input item kinds, carried on tuser.
	localparam int MODE_W = 2;
	typedef enum logic [MODE_W-1:0] {
		MODE_COEF  = 2'd0,
		MODE_PIXEL = 2'd1,
		MODE_FLUSH = 2'd2
	} c2d_mode_t;

	// Input tdata layout.
	localparam int COEF_IDX_W  = 5;
	localparam int COEF_W      = 16;
	localparam int PIXEL_W     = 8;
	localparam int IN_ROW_LSB  = 0;
	localparam int IN_COL_LSB  = IN_ROW_LSB + COEF_IDX_W;
	localparam int IN_COEF_LSB = IN_COL_LSB + COEF_IDX_W;
	localparam int IN_PIX_LSB  = IN_COEF_LSB + COEF_W;
	localparam int IN_TDATA_W  = 40;

	// Output tdata layout.
	localparam int RESULT_W     = 32;
	localparam int OUT_ROW_W    = 10;
	localparam int OUT_COL_W    = 10;
	localparam int OUT_ROW_LSB  = RESULT_W;
	localparam int OUT_COL_LSB  = OUT_ROW_LSB + OUT_ROW_W;
	localparam int OUT_TDATA_W  = 56;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_step;
		logic px_write;
		logic coef_write;
		logic skip_adv;
		logic div_start;
		logic div_step;
		logic tap_init;
		logic tap_step;
		logic out_load;
	} c2d_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic      in_fire;
		c2d_mode_t in_mode;
		logic      clr_last;
		logic      early;
		logic      div_last;
		logic      tap_last;
		logic      out_free;
	} c2d_sts_t;

endpackage

[rtl/core/c2d_ctrl.sv]
// Sequencing state machine of the 2-D convolution core.
`timescale 1ns / 1ps
module c2d_ctrl import c2d_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  c2d_sts_t sts,
	output c2d_cmd_t cmd,
	output logic     s_tready
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_WAIT,
		S_DECIDE,
		S_DIV,
		S_TAPINIT,
		S_TAP,
		S_DRAIN,
		S_OUT
	} state_t;

	localparam logic [1:0] WAIT_LAST = 2'd3;

	state_t     state_q, state_d;
	logic [1:0] cnt_q;
	logic       ready_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (sts.in_fire) begin
					case (sts.in_mode)
						MODE_PIXEL, MODE_FLUSH: begin
							cmd.px_write = 1'b1;
							state_d      = S_WAIT;
						end
						MODE_COEF: cmd.coef_write = 1'b1;
						default: ;
					endcase
				end
			end
			S_WAIT: begin
				if (cnt_q == WAIT_LAST) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.early) begin
					cmd.skip_adv = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_TAPINIT;
			end
			S_TAPINIT: begin
				cmd.tap_init = 1'b1;
				state_d      = S_TAP;
			end
			S_TAP: begin
				cmd.tap_step = 1'b1;
				if (sts.tap_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (cnt_q == WAIT_LAST) state_d = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q   <= '0;
			ready_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ready_q <= (state_d == S_IDLE);
			if (state_d != state_q) cnt_q <= '0;
			else cnt_q <= cnt_q + 2'd1;
		end
	end

	assign s_tready = ready_q;

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded while output register still occupied");

	a_px_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.px_write |=> (state_q == S_WAIT))
		else $error("pixel write not followed by settle wait");

	a_tap_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TAP && sts.tap_last) |=> (state_q == S_DRAIN))
		else $error("window scan did not end after its last tap");

endmodule

[rtl/core/c2d_datapath.sv]
// Datapath of the 2-D convolution core: registers, line and coefficient memories, divider, MAC.
`timescale 1ns / 1ps
module c2d_datapath import c2d_pkg::*; #(
	parameter int MAX_KERNEL = MAX_KERNEL_DEF,
	parameter int MAX_COLS   = MAX_COLS_DEF,
	parameter int MAX_ROWS   = MAX_ROWS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_addr,
	input  logic [CFG_W-1:0]       cfg_wdata,
	input  logic                   in_fire,
	input  logic [MODE_W-1:0]      in_tuser,
	input  logic [IN_TDATA_W-1:0]  in_tdata,
	input  logic                   m_tready,
	output logic                   m_tvalid,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tlast,
	input  c2d_cmd_t               cmd,
	output c2d_sts_t               sts
);

	localparam int KW     = $clog2(MAX_KERNEL + 1);
	localparam int RW     = $clog2(MAX_ROWS + 1);
	localparam int CW     = $clog2(MAX_COLS + 1);
	localparam int PW     = $clog2(MAX_ROWS * MAX_COLS + 1);
	localparam int IPW    = PW + 1;
	localparam int SW     = PW + 2;
	localparam int LDEPTH = (MAX_KERNEL - 1) * MAX_COLS + MAX_KERNEL;
	localparam int AW     = $clog2(LDEPTH);
	localparam int CDEPTH = MAX_KERNEL * MAX_KERNEL;
	localparam int CAW    = $clog2(CDEPTH);
	localparam int DCW    = $clog2(PW + 1);

	// Configuration registers.
	logic [DIM_REG_W-1:0] rows_q, cols_q;
	logic [KER_REG_W-1:0] krows_q, kcols_q;
	logic                 sym_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= RST_IMAGE_ROWS;
			cols_q  <= RST_IMAGE_COLS;
			krows_q <= RST_KERNEL_ROWS;
			kcols_q <= RST_KERNEL_COLS;
			sym_q   <= 1'b0;
		end else if (cfg_we) begin
			case (c2d_reg_t'(cfg_addr))
				REG_IMAGE_ROWS:  rows_q  <= cfg_wdata[DIM_REG_W-1:0];
				REG_IMAGE_COLS:  cols_q  <= cfg_wdata[DIM_REG_W-1:0];
				REG_KERNEL_ROWS: krows_q <= cfg_wdata[KER_REG_W-1:0];
				REG_KERNEL_COLS: kcols_q <= cfg_wdata[KER_REG_W-1:0];
				REG_SYM_FOLD:    sym_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Clamped sizes, first derived stage.
	logic [RW-1:0] rdim_c, rdim_q;
	logic [CW-1:0] cdim_c, cdim_q;
	logic [KW-1:0] kr_c, kc_c, kr_q, kc_q, offr_q, offc_q, halfr_q, halfc_q;

	always_comb begin
		if (rows_q == '0) rdim_c = RW'(1);
		else if (32'(rows_q) > MAX_ROWS) rdim_c = RW'(MAX_ROWS);
		else rdim_c = RW'(rows_q);
		if (cols_q == '0) cdim_c = CW'(1);
		else if (32'(cols_q) > MAX_COLS) cdim_c = CW'(MAX_COLS);
		else cdim_c = CW'(cols_q);
		if (krows_q == '0) kr_c = KW'(1);
		else if (32'(krows_q) > MAX_KERNEL) kr_c = KW'(MAX_KERNEL);
		else kr_c = KW'(krows_q);
		if (kcols_q == '0) kc_c = KW'(1);
		else if (32'(kcols_q) > MAX_KERNEL) kc_c = KW'(MAX_KERNEL);
		else kc_c = KW'(kcols_q);
	end

	always_ff @(posedge clk) begin
		rdim_q  <= rdim_c;
		cdim_q  <= cdim_c;
		kr_q    <= kr_c;
		kc_q    <= kc_c;
		offr_q  <= (kr_c - KW'(1)) >> 1;
		offc_q  <= (kc_c - KW'(1)) >> 1;
		halfr_q <= kr_c >> 1;
		halfc_q <= kc_c >> 1;
	end

	// Second derived stage: latency, frame size and window offset.
	logic [AW-1:0] l_q, offrc_q;
	logic [PW-1:0] total_q;

	always_ff @(posedge clk) begin
		l_q     <= AW'(32'(kr_q - KW'(1) - offr_q) * 32'(cdim_q) + 32'(kc_q - KW'(1) - offc_q));
		offrc_q <= AW'(32'(offr_q) * 32'(cdim_q) + 32'(offc_q));
		total_q <= PW'(32'(rdim_q) * 32'(cdim_q));
	end

	// Input fields.
	logic [COEF_IDX_W-1:0] in_crow, in_ccol;
	logic [COEF_W-1:0]     in_coef;
	logic [PIXEL_W-1:0]    in_pix;
	c2d_mode_t             in_mode;

	assign in_crow = in_tdata[IN_ROW_LSB +: COEF_IDX_W];
	assign in_ccol = in_tdata[IN_COL_LSB +: COEF_IDX_W];
	assign in_coef = in_tdata[IN_COEF_LSB +: COEF_W];
	assign in_pix  = in_tdata[IN_PIX_LSB +: PIXEL_W];
	assign in_mode = c2d_mode_t'(in_tuser);

	// Stream positions.
	logic [IPW-1:0] inpos_q;
	logic [PW-1:0]  outpos_q;
	logic [AW-1:0]  wptr_q, outk_q, clr_q;
	logic           last_c;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
		return (a == AW'(LDEPTH - 1)) ? '0 : a + AW'(1);
	endfunction

	assign last_c = ((33'(outpos_q) + 33'd1) >= 33'(total_q));

	// Divider: row and column of the output position.
	logic [CW-1:0]  dv_rem_q;
	logic [PW-1:0]  dv_quo_q;
	logic [DCW-1:0] dv_cnt_q;
	logic [CW:0]    rem_sh;
	logic           rem_ge;

	assign rem_sh = {dv_rem_q, dv_quo_q[PW-1]};
	assign rem_ge = (rem_sh >= {1'b0, cdim_q});

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dv_rem_q <= '0;
			dv_quo_q <= outpos_q;
			dv_cnt_q <= DCW'(PW);
		end else if (cmd.div_step) begin
			dv_rem_q <= rem_ge ? CW'(rem_sh - {1'b0, cdim_q}) : CW'(rem_sh);
			dv_quo_q <= {dv_quo_q[PW-2:0], rem_ge};
			dv_cnt_q <= dv_cnt_q - DCW'(1);
		end
	end

	// Window scan.
	logic [KW-1:0]        ic_q, jc_q, icm, jcm, icr, jcr, crow, ccol;
	logic                 skip;
	logic signed [SW-1:0] r_q, c_q, c0_q;
	logic [AW-1:0]        rs_q, la_q, rs_next;
	logic [AW:0]          rs_sum;
	logic signed [AW+1:0] base_diff;
	logic [AW-1:0]        base;
	logic [CAW-1:0]       caddr;
	logic                 tap_ok, row_end;

	always_comb begin
		icr = kr_q - KW'(1) - ic_q;
		jcr = kc_q - KW'(1) - jc_q;
		if (sym_q) begin
			icm  = (ic_q < halfr_q) ? ic_q : icr;
			jcm  = (jc_q < halfc_q) ? jc_q : jcr;
			skip = (!(ic_q < halfr_q) && !(icr < halfr_q))
			    || (!(jc_q < halfc_q) && !(jcr < halfc_q));
		end else begin
			icm  = ic_q;
			jcm  = jc_q;
			skip = 1'b0;
		end
		crow  = kr_q - KW'(1) - icm;
		ccol  = kc_q - KW'(1) - jcm;
		caddr = CAW'(32'(crow) * MAX_KERNEL + 32'(ccol));
	end

	assign tap_ok = !skip && (r_q >= 0) && (r_q < $signed(SW'(rdim_q)))
	             && (c_q >= 0) && (c_q < $signed(SW'(cdim_q)));
	assign row_end = (jc_q == kc_q - KW'(1));
	assign rs_sum  = {1'b0, rs_q} + (AW+1)'(cdim_q);
	assign rs_next = (rs_sum >= (AW+1)'(LDEPTH)) ? AW'(rs_sum - (AW+1)'(LDEPTH)) : AW'(rs_sum);
	assign base_diff = $signed({2'b00, outk_q}) - $signed({2'b00, offrc_q});
	assign base = (base_diff < 0) ? AW'(base_diff + (AW+2)'(LDEPTH)) : AW'(base_diff);

	always_ff @(posedge clk) begin
		if (cmd.tap_init) begin
			ic_q <= '0;
			jc_q <= '0;
			r_q  <= $signed({2'b00, dv_quo_q}) - $signed(SW'(offr_q));
			c_q  <= $signed(SW'(dv_rem_q)) - $signed(SW'(offc_q));
			c0_q <= $signed(SW'(dv_rem_q)) - $signed(SW'(offc_q));
			rs_q <= base;
			la_q <= base;
		end else if (cmd.tap_step) begin
			if (row_end) begin
				jc_q <= '0;
				ic_q <= ic_q + KW'(1);
				r_q  <= r_q + SW'(1);
				c_q  <= c0_q;
				rs_q <= rs_next;
				la_q <= rs_next;
			end else begin
				jc_q <= jc_q + KW'(1);
				c_q  <= c_q + SW'(1);
				la_q <= wrap_inc(la_q);
			end
		end
	end

	// Memories.
	logic [PIXEL_W-1:0] lmem [LDEPTH];
	logic [COEF_W-1:0]  cmem [CDEPTH];
	logic [PIXEL_W-1:0] px_s1;
	logic [COEF_W-1:0]  coef_s1;

	always_ff @(posedge clk) begin
		if (cmd.clr_step) lmem[clr_q] <= '0;
		else if (cmd.px_write) lmem[wptr_q] <= (in_mode == MODE_PIXEL) ? in_pix : '0;
		px_s1 <= lmem[la_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.coef_write && (32'(in_crow) < MAX_KERNEL) && (32'(in_ccol) < MAX_KERNEL))
			cmem[CAW'(32'(in_crow) * MAX_KERNEL + 32'(in_ccol))] <= in_coef;
		coef_s1 <= cmem[caddr];
	end

	// Multiply-accumulate.
	logic               vld_s1;
	logic signed [24:0] prod_s2;
	logic [RESULT_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		prod_s2 <= vld_s1 ? $signed({1'b0, px_s1}) * $signed(coef_s1) : 25'sd0;
		if (cmd.tap_init) acc_q <= '0;
		else acc_q <= acc_q + {{(RESULT_W - 25){prod_s2[24]}}, prod_s2};
	end

	// Control registers: positions, clear sweep, tap valid, output valid.
	logic                 m_valid_q;
	logic [RESULT_W-1:0]  res_q;
	logic [OUT_ROW_W-1:0] orow_q;
	logic [OUT_COL_W-1:0] ocol_q;
	logic                 olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inpos_q   <= '0;
			outpos_q  <= '0;
			wptr_q    <= '0;
			outk_q    <= '0;
			clr_q     <= '0;
			vld_s1    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.tap_step && tap_ok;
			if (cmd.clr_step) clr_q <= wrap_inc(clr_q);
			if (cmd.skip_adv) begin
				inpos_q <= inpos_q + IPW'(1);
				wptr_q  <= wrap_inc(wptr_q);
			end else if (cmd.out_load) begin
				if (last_c) begin
					inpos_q  <= '0;
					outpos_q <= '0;
					wptr_q   <= '0;
					outk_q   <= '0;
				end else begin
					inpos_q  <= inpos_q + IPW'(1);
					outpos_q <= outpos_q + PW'(1);
					wptr_q   <= wrap_inc(wptr_q);
					outk_q   <= wrap_inc(outk_q);
				end
			end
			if (cmd.out_load) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q   <= acc_q;
			orow_q  <= OUT_ROW_W'(dv_quo_q);
			ocol_q  <= OUT_COL_W'(dv_rem_q);
			olast_q <= last_c;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - OUT_COL_LSB - OUT_COL_W){1'b0}}, ocol_q, orow_q, res_q};
	assign m_tlast  = olast_q;

	assign sts.in_fire  = in_fire;
	assign sts.in_mode  = in_mode;
	assign sts.clr_last = (clr_q == AW'(LDEPTH - 1));
	assign sts.early    = (33'(inpos_q) < 33'(l_q));
	assign sts.div_last = (dv_cnt_q == DCW'(1));
	assign sts.tap_last = row_end && (ic_q == kr_q - KW'(1));
	assign sts.out_free = !m_valid_q || m_tready;

endmodule

[rtl/core/conv2d_same_zero_padded_core.sv]
// Top level of the same-size zero-padded 2-D convolution core.
//
// Channel   Direction  Handshake          Carries
// s_*       in         s_tvalid/s_tready  coefficient loads, pixels and flush ticks
// m_*       out        m_tvalid/m_tready  one convolution result per output pixel
// cfg_*     in         cfg_we only        image and kernel sizes, fold select
//
// A coefficient load is written while the core stays idle. A pixel or flush item that
// produces no result yet passes the settle wait and the decision and returns to idle;
// one that produces a result also passes the bit-serial row/column divider over the
// PW-bit output position (PW is 21 by default) and the KR*KC-tap window scan, one tap
// per cycle through the single read port of the line memory, then drains and emits.
// After reset the line memory is swept to zero, one entry per cycle over all
// (MAX_KERNEL-1)*MAX_COLS+MAX_KERNEL entries (17426 by default); s_tready stays low.
// A finished result waits in the output register while the next input transfer is
// taken; a stalled output holds the core before the next result is loaded.
`timescale 1ns / 1ps
module conv2d_same_zero_padded_core import c2d_pkg::*; #(
	parameter int MAX_KERNEL = MAX_KERNEL_DEF,
	parameter int MAX_COLS   = MAX_COLS_DEF,
	parameter int MAX_ROWS   = MAX_ROWS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration writes: cfg_addr selects the register, cfg_wdata holds its value.
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_addr,
	input  logic [CFG_W-1:0]       cfg_wdata,
	// Input stream.
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// s_tdata: coef_row[4:0], coef_col[9:5], coefficient[25:10], pixel[33:26], zeros above.
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// s_tuser: mode[1:0].
	input  logic [MODE_W-1:0]      s_tuser,
	// Output stream.
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// m_tdata: result[31:0], out_row[41:32], out_col[51:42], zeros above.
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// m_tlast: marks the final output pixel of the frame.
	output logic                   m_tlast
);

	c2d_cmd_t cmd;
	c2d_sts_t sts;
	logic     in_fire;

	// An input transfer completes when both sides of the handshake agree.
	assign in_fire = s_tvalid && s_tready;

	// The controller sequences each item: settle, decide, divide, scan, drain, emit.
	c2d_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.sts      (sts),
		.cmd      (cmd),
		.s_tready (s_tready)
	);

	// The datapath owns the registers, the line and coefficient memories and the MAC.
	c2d_datapath #(
		.MAX_KERNEL (MAX_KERNEL),
		.MAX_COLS   (MAX_COLS),
		.MAX_ROWS   (MAX_ROWS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_fire   (in_fire),
		.in_tuser  (s_tuser),
		.in_tdata  (s_tdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
